### hw/rtl/fcs_pkg.sv
`default_nettype none

package fcs_pkg;

  localparam int unsigned RING_SIZE   = 16;
  localparam int unsigned RING_IDX_W  = 4;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned ARC_W       = 5;
  localparam int unsigned BORDER      = 3;
  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  // merge unit stage enables: select, partial min, final min
  localparam int unsigned MERGE_STAGES = 3;

  localparam logic [PIX_W-1:0] MIN_RESET = 8'hFF;

  localparam logic [PIX_W-1:0] THR_RESET    = 8'd20;
  localparam logic [ARC_W-1:0] ARC_RESET    = 5'd9;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ARC       = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_HEIGHT    = 2'd3
  } cfg_idx_e;

  typedef logic [RING_SIZE-1:0][PIX_W-1:0] ring_t;

  typedef struct packed {
    logic [RING_SIZE-1:0] bright;
    logic [RING_SIZE-1:0] dark;
    logic                 in_frame;
  } cls_t;

  typedef struct packed {
    logic                 hit;
    logic [RING_SIZE-1:0] mask;
  } lane_res_t;

  typedef lane_res_t [RING_SIZE-1:0] lane_arr_t;

  // Arc window starting at ring index 0; zero arc counts as one, 16 and up cover the ring.
  function automatic logic [RING_SIZE-1:0] win_base(input logic [ARC_W-1:0] arc);
    logic [ARC_W-1:0]     a;
    logic [RING_SIZE-1:0] m;
    a = (arc == '0) ? ARC_W'(1) : arc;
    for (int i = 0; i < RING_SIZE; i++) begin
      m[i] = (ARC_W'(i) < a);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fcs_classify.sv
`default_nettype none

module fcs_classify import fcs_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [PIX_W-1:0]  center_i,
  input  wire ring_t             ring_i,
  input  wire logic [POS_W-1:0]  pos_x_i,
  input  wire logic [POS_W-1:0]  pos_y_i,
  input  wire logic [PIX_W-1:0]  thr_i,
  input  wire logic [DIM_W-1:0]  width_i,
  input  wire logic [DIM_W-1:0]  height_i,
  output cls_t                   cls_o,
  output ring_t                  diff_o
);

  localparam int unsigned DimNeedW = $clog2(MAX_DIM + 1);
  localparam int unsigned LimW     = (DimNeedW > DIM_W + 1) ? DimNeedW : DIM_W + 1;

  logic [LimW-1:0]  max_dim;
  logic [LimW-1:0]  w_ext, h_ext, lim_w, lim_h, x_far, y_far;
  logic [PIX_W:0]   hi_lim;
  logic [PIX_W:0]   v_thr;
  logic [PIX_W-1:0] v;
  cls_t             cls_d, cls_q;
  ring_t            diff_d, diff_q;

  always_comb begin
    hi_lim = {1'b0, center_i} + {1'b0, thr_i};
    v      = '0;
    v_thr  = '0;
    cls_d  = '0;
    diff_d = '0;
    for (int i = 0; i < RING_SIZE; i++) begin
      v               = ring_i[i];
      v_thr           = {1'b0, v} + {1'b0, thr_i};
      cls_d.bright[i] = ({1'b0, v} > hi_lim);
      cls_d.dark[i]   = (v_thr < {1'b0, center_i});
      diff_d[i]       = (v >= center_i) ? (v - center_i) : (center_i - v);
    end

    // border test: in frame when 3 <= pos and pos + 3 < clamped dimension
    max_dim = LimW'(MAX_DIM);
    w_ext   = LimW'(width_i);
    h_ext   = LimW'(height_i);
    lim_w   = (w_ext > max_dim) ? max_dim : w_ext;
    lim_h   = (h_ext > max_dim) ? max_dim : h_ext;
    x_far   = LimW'(pos_x_i) + LimW'(BORDER);
    y_far   = LimW'(pos_y_i) + LimW'(BORDER);
    cls_d.in_frame = (pos_x_i >= POS_W'(BORDER)) && (pos_y_i >= POS_W'(BORDER))
                     && (x_far < lim_w) && (y_far < lim_h);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q  <= cls_d;
      diff_q <= diff_d;
    end
  end

  assign cls_o  = cls_q;
  assign diff_o = diff_q;

endmodule

`default_nettype wire

### hw/rtl/fcs_lane.sv
`default_nettype none

// One start index of the ring: is the arc window starting here uniform, and which
// ring pixels feed the running minimum if the scan stops at its end.
module fcs_lane import fcs_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire cls_t                 cls_i,
  input  wire logic [RING_SIZE-1:0] win_base_i,
  output lane_res_t                 res_o
);

  logic [RING_SIZE-1:0] win, pre, nn;
  logic                 run;
  lane_res_t            res_d, res_q;

  always_comb begin
    nn  = cls_i.bright | cls_i.dark;
    win = '0;
    for (int i = 0; i < RING_SIZE; i++) begin
      win[RING_IDX_W'(i + LANE)] = win_base_i[i];
    end
    // pixels before the start back to the last neutral one
    run = 1'b1;
    pre = '0;
    for (int j = RING_SIZE - 1; j >= 0; j--) begin
      if (j < LANE) begin
        run    = run & nn[j];
        pre[j] = run;
      end
    end
    res_d.hit  = ((win & ~cls_i.bright) == '0) || ((win & ~cls_i.dark) == '0);
    res_d.mask = win | pre;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/fcs_merge.sv
`default_nettype none

module fcs_merge import fcs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic [MERGE_STAGES-1:0] en_i,
  input  wire lane_arr_t               lanes_i,
  input  wire ring_t                   diff_i,
  input  wire logic                    in_frame_i,
  output logic [PIX_W-1:0]             response_o,
  output logic                         found_o
);

  localparam int unsigned Groups = RING_SIZE / 4;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // select: earliest start index with a uniform window
  logic [RING_SIZE-1:0] sel_mask_d, sel_mask_q;
  logic                 any_hit;
  logic                 found3_d, found3_q, found4_q, found5_q;
  ring_t                diff3_q;

  always_comb begin
    sel_mask_d = '0;
    any_hit    = 1'b0;
    for (int p = RING_SIZE - 1; p >= 0; p--) begin
      if (lanes_i[p].hit) begin
        sel_mask_d = lanes_i[p].mask;
        any_hit    = 1'b1;
      end
    end
    found3_d = any_hit & in_frame_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sel_mask_q <= sel_mask_d;
      found3_q   <= found3_d;
      diff3_q    <= diff_i;
    end
  end

  // min tree, two levels per stage
  logic [Groups-1:0][PIX_W-1:0] part_d, part_q;
  logic [PIX_W-1:0]             m0, m1, m2, m3;
  logic [PIX_W-1:0]             resp_d, resp_q;

  always_comb begin
    part_d = '0;
    for (int g = 0; g < Groups; g++) begin
      m0 = sel_mask_q[4*g]     ? diff3_q[4*g]     : MIN_RESET;
      m1 = sel_mask_q[4*g + 1] ? diff3_q[4*g + 1] : MIN_RESET;
      m2 = sel_mask_q[4*g + 2] ? diff3_q[4*g + 2] : MIN_RESET;
      m3 = sel_mask_q[4*g + 3] ? diff3_q[4*g + 3] : MIN_RESET;
      part_d[g] = min2(min2(m0, m1), min2(m2, m3));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      part_q   <= part_d;
      found4_q <= found3_q;
    end
  end

  always_comb begin
    resp_d = min2(min2(part_q[0], part_q[1]), min2(part_q[2], part_q[3]));
    if (!found4_q) begin
      resp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      resp_q   <= resp_d;
      found5_q <= found4_q;
    end
  end

  assign response_o = resp_q;
  assign found_o    = found5_q;

endmodule

`default_nettype wire

### hw/rtl/fast_corner_score_core.sv
`default_nettype none

// FAST segment-test corner response, one candidate pixel per beat. Sixteen lanes, one per
// ring start index, test in parallel whether the arc window from that index is all brighter
// or all darker than the center; the merge unit takes the earliest such lane and forms the
// minimum absolute difference since the last neutral ring pixel. Throughput is one beat per
// clock while the output does not stall; each of the five stages has its own valid bit, so
// stalls on the output only fill bubbles upstream. Registers: 0 intensity threshold, 1 arc
// length, 2 frame width, 3 frame height; write them only while idle.
// Positions within 3 pixels of the frame edge report no corner and a response of 0.
module fast_corner_score_core import fcs_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      center_pixel_i,
  input  wire logic [63:0]           ring_first_half_i,
  input  wire logic [63:0]           ring_second_half_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PIX_W-1:0]           corner_response_o,
  output logic                       corner_found_o
);

  localparam int unsigned NumStages = 2 + MERGE_STAGES;

  // configuration
  logic [PIX_W-1:0] thr_q;
  logic [ARC_W-1:0] arc_q;
  logic [DIM_W-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      arc_q    <= ARC_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: thr_q    <= cfg_data_i[PIX_W-1:0];
        CFG_ARC:       arc_q    <= cfg_data_i[ARC_W-1:0];
        CFG_WIDTH:     width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // stage valids; a stage loads when it is empty or its successor moves
  logic [NumStages-1:0] vld_d, vld_q, rdy;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < NumStages; s++) begin
      vld_d[s] = rdy[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // stage 1: classify ring pixels, border test
  cls_t  cls1;
  ring_t diff1;

  fcs_classify #(
    .MAX_DIM (MAX_DIM)
  ) u_classify (
    .clk_i    (clk_i),
    .en_i     (rdy[0]),
    .center_i (center_pixel_i),
    .ring_i   (ring_t'({ring_second_half_i, ring_first_half_i})),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .thr_i    (thr_q),
    .width_i  (width_q),
    .height_i (height_q),
    .cls_o    (cls1),
    .diff_o   (diff1)
  );

  // stage 2: one lane per start index
  logic [RING_SIZE-1:0] win_base_w;
  lane_arr_t            lanes2;
  ring_t                diff2_q;
  logic                 in_frame2_q;

  assign win_base_w = win_base(arc_q);

  for (genvar p = 0; p < RING_SIZE; p++) begin : g_lane
    fcs_lane #(
      .LANE (p)
    ) u_lane (
      .clk_i      (clk_i),
      .en_i       (rdy[1]),
      .cls_i      (cls1),
      .win_base_i (win_base_w),
      .res_o      (lanes2[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      diff2_q     <= diff1;
      in_frame2_q <= cls1.in_frame;
    end
  end

  // stages 3 to 5: pick lane, min tree, output register
  fcs_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (rdy[NumStages-1:2]),
    .lanes_i    (lanes2),
    .diff_i     (diff2_q),
    .in_frame_i (in_frame2_q),
    .response_o (corner_response_o),
    .found_o    (corner_found_o)
  );

  a_no_corner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !corner_found_o |-> corner_response_o == '0)
    else $error("response nonzero without a corner");

  a_corner_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && corner_found_o |-> corner_response_o != '0)
    else $error("corner with zero response");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire

### tb/fcs_score_checker.sv
module fcs_score_checker import fcs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [PIX_W-1:0]      center_pixel_i,
  input  wire logic [63:0]           ring_first_half_i,
  input  wire logic [63:0]           ring_second_half_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [PIX_W-1:0]      corner_response_i,
  input  wire logic                  corner_found_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] response;
    logic             found;
  } corner_t;

  corner_t          corner_exp_q[$];
  logic [PIX_W-1:0] thr_q;
  logic [ARC_W-1:0] arc_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  function automatic corner_t predict_corner(input logic [PIX_W-1:0] center,
                                             input logic [127:0] ring,
                                             input logic [POS_W-1:0] px,
                                             input logic [POS_W-1:0] py);
    corner_t              res;
    int                   c, thr, arc, w, h, x, y, edge_gap, ring_n;
    int                   v, d, k, idx, bright_run, dark_run, run_min;
    logic [RING_SIZE-1:0] brighter, darker;
    bit                   hit;
    res      = '0;
    c        = center;
    thr      = thr_q;
    arc      = (arc_q == '0) ? 1 : arc_q;
    w        = (width_q > MAX_DIM_DEF) ? MAX_DIM_DEF : width_q;
    h        = (height_q > MAX_DIM_DEF) ? MAX_DIM_DEF : height_q;
    x        = px;
    y        = py;
    edge_gap = BORDER;
    ring_n   = RING_SIZE;
    if (x < edge_gap || y < edge_gap || x >= w - edge_gap || y >= h - edge_gap) begin
      return res;
    end
    for (k = 0; k < ring_n; k++) begin
      v           = ring[8*k +: 8];
      brighter[k] = (v > c + thr);
      darker[k]   = (v < c - thr);
    end
    bright_run = 0;
    dark_run   = 0;
    run_min    = 255;
    hit        = 1'b0;
    // scan wraps past the end so a run straddling index 0 is still seen
    for (k = 0; k < ring_n + arc && !hit; k++) begin
      idx = k % ring_n;
      v   = ring[8*idx +: 8];
      if (brighter[idx]) begin
        d = v - c;
        bright_run++;
        dark_run = 0;
        if (d < run_min) run_min = d;
      end else if (darker[idx]) begin
        d = c - v;
        dark_run++;
        bright_run = 0;
        if (d < run_min) run_min = d;
      end else begin
        // only a neutral pixel restarts the minimum, a sign flip does not
        bright_run = 0;
        dark_run   = 0;
        run_min    = 255;
      end
      if (bright_run >= arc || dark_run >= arc) begin
        hit          = 1'b1;
        res.response = run_min[PIX_W-1:0];
        res.found    = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    corner_t want;
    if (!rst_ni) begin
      thr_q    = THR_RESET;
      arc_q    = ARC_RESET;
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      corner_exp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (corner_exp_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: response %0d found %0b",
                   $time, corner_response_i, corner_found_i);
          fail_count_o++;
        end else begin
          want = corner_exp_q.pop_front();
          if (corner_response_i !== want.response) begin
            $display("%0t: corner_response expected %0d, got %0d",
                     $time, want.response, corner_response_i);
            fail_count_o++;
          end
          if (corner_found_i !== want.found) begin
            $display("%0t: corner_found expected %0b, got %0b",
                     $time, want.found, corner_found_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_THRESHOLD: thr_q    = cfg_data_i[PIX_W-1:0];
          CFG_ARC:       arc_q    = cfg_data_i[ARC_W-1:0];
          CFG_WIDTH:     width_q  = cfg_data_i;
          CFG_HEIGHT:    height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        corner_exp_q.push_back(predict_corner(center_pixel_i,
                                              {ring_second_half_i, ring_first_half_i},
                                              pos_x_i, pos_y_i));
      end
      pending_o = corner_exp_q.size();
    end
  end

endmodule

### tb/fast_corner_score_core_tb.sv
module fast_corner_score_core_tb import fcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 80;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      center_pixel;
  logic [63:0]           ring_first_half;
  logic [63:0]           ring_second_half;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      corner_response;
  logic                  corner_found;

  int fail_count;
  int pending_results;
  int burst_left  = 0;
  bit sender_gaps = 1'b1;
  int hold_req    = 0;
  int hold_ack    = 0;

  fast_corner_score_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .center_pixel_i     (center_pixel),
    .ring_first_half_i  (ring_first_half),
    .ring_second_half_i (ring_second_half),
    .pos_x_i            (pos_x),
    .pos_y_i            (pos_y),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .corner_response_o  (corner_response),
    .corner_found_o     (corner_found)
  );

  fcs_score_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .center_pixel_i     (center_pixel),
    .ring_first_half_i  (ring_first_half),
    .ring_second_half_i (ring_second_half),
    .pos_x_i            (pos_x),
    .pos_y_i            (pos_y),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .corner_response_i  (corner_response),
    .corner_found_i     (corner_found),
    .fail_count_o       (fail_count),
    .pending_o          (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic reg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // bursts of back-to-back beats, a random gap before most new bursts while gaps are enabled
  task automatic send_pixel(input logic [PIX_W-1:0] c, input ring_t r,
                            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid         <= 1'b1;
    center_pixel     <= c;
    ring_first_half  <= r[7:0];
    ring_second_half <= r[15:8];
    pos_x            <= x;
    pos_y            <= y;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    rx_mode_e mode;
    int       run_left;
    int       tick;
    mode      = RX_ALWAYS;
    run_left  = 0;
    tick      = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ack != hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_ack++;
      end else begin
        if (run_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          run_left = $urandom_range(8, 64);
        end
        case (mode)
          RX_ALWAYS:   out_ready <= 1'b1;
          RX_HALF:     out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready <= (tick % 3 != 0);
          default:     out_ready <= 1'b1;
        endcase
        tick++;
        run_left--;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("fast_corner_score_core regression: fail");
    $finish;
  end

  initial begin
    ring_t                 ring;
    logic [CFG_DATA_W-1:0] thr_d, arc_d, w_d, h_d;
    logic [POS_W-1:0]      x, y;
    int                    cur_thr, cur_arc, cur_w, cur_h;
    int                    c, a, shape, run_len, start, sign, cls, lo_v, hi_v;
    int                    sel, ew, eh, n_items;

    rst_ni           <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_THRESHOLD;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    center_pixel     <= '0;
    ring_first_half  <= '0;
    ring_second_half <= '0;
    pos_x            <= '0;
    pos_y            <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at the reset settings: thr 20, arc 9, 640x480
    send_pixel(8'd0, {RING_SIZE{8'd255}}, 12'd320, 12'd240);
    send_pixel(8'd255, {RING_SIZE{8'd0}}, 12'd320, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd100}}, 12'd320, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd120}}, 12'd320, 12'd240);  // exactly at threshold
    send_pixel(8'd100, {RING_SIZE{8'd121}}, 12'd320, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd79}}, 12'd320, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd80}}, 12'd320, 12'd240);
    // border edges, each side on and one inside
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd2, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd3, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd636, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd637, 12'd240);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd320, 12'd2);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd320, 12'd3);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd320, 12'd476);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd320, 12'd477);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd4095, 12'd4095);
    send_pixel(8'd100, {RING_SIZE{8'd200}}, 12'd0, 12'd0);
    ring = {RING_SIZE{8'd100}};
    for (int i = 0; i < 9; i++) ring[i] = 8'd150;
    send_pixel(8'd100, ring, 12'd320, 12'd240);
    // dark run wrapping through index 0
    ring = {RING_SIZE{8'd100}};
    for (int i = 0; i < 9; i++) ring[(12 + i) % RING_SIZE] = 8'd40;
    send_pixel(8'd100, ring, 12'd320, 12'd240);
    // one short of the arc
    ring = {RING_SIZE{8'd100}};
    for (int i = 2; i < 10; i++) ring[i] = 8'd150;
    send_pixel(8'd100, ring, 12'd320, 12'd240);
    // bright lead-in then dark arc: minimum carries across the sign flip
    ring = {RING_SIZE{8'd100}};
    for (int i = 0; i < 4; i++) ring[i] = 8'd121;
    for (int i = 4; i < 13; i++) ring[i] = 8'd50;
    send_pixel(8'd100, ring, 12'd320, 12'd240);
    for (int i = 0; i < RING_SIZE; i++) ring[i] = i[0] ? 8'd255 : 8'd0;
    send_pixel(8'd128, ring, 12'd320, 12'd240);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin thr_d = 0;   arc_d = 1;  w_d = 8191; h_d = 8191; n_items = 250; end
        1: begin thr_d = 255; arc_d = 16; w_d = 4096; h_d = 4096; n_items = 40;  end
        2: begin thr_d = 8;   arc_d = 16; w_d = 4096; h_d = 4096; n_items = 230; end
        3: begin thr_d = 10;  arc_d = 0;  w_d = 7;    h_d = 7;    n_items = 120; end
        4: begin thr_d = 35;  arc_d = 31; w_d = 6;    h_d = 480;  n_items = 60;  end
        5: begin thr_d = 20;  arc_d = 12; w_d = 1000; h_d = 5000; n_items = 230; end
        6: begin
          // raw 13-bit data, upper bits of the narrow registers included
          thr_d = CFG_DATA_W'($urandom_range(0, 8191));
          arc_d = CFG_DATA_W'($urandom_range(0, 8191));
          w_d   = CFG_DATA_W'($urandom_range(0, 8191));
          h_d   = CFG_DATA_W'($urandom_range(0, 8191));
          n_items = 170;
        end
        7: begin thr_d = 5;   arc_d = 9;  w_d = 640;  h_d = 480;  n_items = 190; end
        default: begin thr_d = 60; arc_d = 17; w_d = 0; h_d = 0; n_items = 40; end
      endcase
      reg_write(CFG_THRESHOLD, thr_d);
      reg_write(CFG_ARC, arc_d);
      reg_write(CFG_WIDTH, w_d);
      reg_write(CFG_HEIGHT, h_d);
      cfg_valid <= 1'b0;
      cur_thr = thr_d[PIX_W-1:0];
      cur_arc = arc_d[ARC_W-1:0];
      cur_w   = w_d;
      cur_h   = h_d;
      ew = (cur_w > MAX_DIM_DEF) ? MAX_DIM_DEF : cur_w;
      eh = (cur_h > MAX_DIM_DEF) ? MAX_DIM_DEF : cur_h;
      a  = (cur_arc == 0) ? 1 : ((cur_arc > 16) ? 16 : cur_arc);
      sender_gaps = (p != 7);
      if (p == 0 || p == 5 || p == 7) hold_req++;

      for (int n = 0; n < n_items; n++) begin
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(40, 215);
        // shape 0: raw noise, 1: all neutral, 2: full-ring run, else run near arc
        shape   = $urandom_range(0, 9);
        run_len = (shape == 1) ? 0 :
                  (shape == 2) ? 16 : $urandom_range((a > 2) ? a - 2 : 0, (a < 16) ? a + 1 : 16);
        start   = $urandom_range(0, 15);
        sign    = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < RING_SIZE; k++) begin
          if (shape == 0) begin
            ring[k] = PIX_W'($urandom_range(0, 255));
          end else begin
            if ((k - start + 16) % 16 < run_len)
              cls = sign;
            else
              cls = (shape == 1) ? 0 : int'($urandom_range(0, 2)) - 1;
            lo_v = c + cur_thr + 1;
            hi_v = c - cur_thr - 1;
            if (cls == 1 && lo_v <= 255) begin
              ring[k] = $urandom_range(0, 1) ?
                        PIX_W'($urandom_range(lo_v, (lo_v + 2 > 255) ? 255 : lo_v + 2)) :
                        PIX_W'($urandom_range(lo_v, 255));
            end else if (cls == -1 && hi_v >= 0) begin
              ring[k] = $urandom_range(0, 1) ?
                        PIX_W'($urandom_range((hi_v < 2) ? 0 : hi_v - 2, hi_v)) :
                        PIX_W'($urandom_range(0, hi_v));
            end else begin
              ring[k] = PIX_W'($urandom_range((c - cur_thr < 0) ? 0 : c - cur_thr,
                                              (c + cur_thr > 255) ? 255 : c + cur_thr));
            end
          end
        end
        sel = $urandom_range(0, 19);
        if (sel < 2 || ew < 7 || eh < 7) begin
          x = POS_W'($urandom_range(0, 4095));
          y = POS_W'($urandom_range(0, 4095));
        end else begin
          x = POS_W'($urandom_range(3, ew - 4));
          y = POS_W'($urandom_range(3, eh - 4));
          if (sel < 4)
            x = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 5)) :
                                       POS_W'($urandom_range(ew - 6, ew - 1));
          else if (sel < 6)
            y = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 5)) :
                                       POS_W'($urandom_range(eh - 6, eh - 1));
        end
        send_pixel(c[PIX_W-1:0], ring, x, y);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("fast_corner_score_core regression: pass");
    else
      $display("fast_corner_score_core regression: fail");
    $finish;
  end

endmodule

### fast_corner_score_core.f
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_classify.sv
hw/rtl/fcs_lane.sv
hw/rtl/fcs_merge.sv
hw/rtl/fast_corner_score_core.sv
tb/fcs_score_checker.sv
tb/fast_corner_score_core_tb.sv
